### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the path counter.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a condition implies another one in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another one in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/tspc_pkg.sv
// Package of the two-step path counter: widths, op codes and state codes.
// No dependencies.
`default_nettype none

package tspc_pkg;

  localparam int unsigned MAX_VERTICES = 8;
  localparam int unsigned VTX_W        = 3;
  localparam int unsigned ROW_DEPTH    = 2 ** VTX_W;
  localparam int unsigned CNT_W        = 4;
  localparam int unsigned OP_W         = 2;

  typedef logic [VTX_W-1:0]     vtx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [ROW_DEPTH-1:0] row_t;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_EDGE   = 2'd1,
    OP_SQUARE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

endpackage

`default_nettype wire

### hw/rtl/tspc_in_if.sv
// Input channel of the two-step path counter: valid/ready plus one item.
// Depends on tspc_pkg.
`default_nettype none

interface tspc_in_if;
  logic                     valid;
  logic                     ready;
  logic [tspc_pkg::OP_W-1:0] op;
  tspc_pkg::vtx_t           source_vertex;
  tspc_pkg::vtx_t           target_vertex;

  modport source (output valid, output op, output source_vertex, output target_vertex,
                  input ready);
  modport sink   (input valid, input op, input source_vertex, input target_vertex,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/tspc_out_if.sv
// Result channel of the two-step path counter: valid/ready plus one result.
// Depends on tspc_pkg.
`default_nettype none

interface tspc_out_if;
  logic           valid;
  logic           ready;
  tspc_pkg::vtx_t row_index;
  tspc_pkg::vtx_t column_index;
  tspc_pkg::cnt_t walk_count;
  logic           last;

  modport source (output valid, output row_index, output column_index,
                  output walk_count, output last, input ready);
  modport sink   (input valid, input row_index, input column_index,
                  input walk_count, input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/two_step_path_counter.sv
// Top level of the two-step path counter: adjacency matrix and square sequencer.
// Depends on tspc_pkg, tspc_in_if, tspc_out_if and assert_macros.svh.
//
// The block holds an 8x8 0/1 adjacency matrix in flip-flops. A clear or edge
// item is taken whenever the block is idle. A square item walks the active
// rows and columns with one shared AND-and-popcount unit, one matrix entry per
// cycle unless the result side stalls, and the input stays not ready until all
// n*n entries (n = vertex count saturated to MAX_VERTICES) have been emitted;
// with n = 0 it is taken and emits nothing. Results leave through an output
// register, row-major, with last on the final entry.
// Write the vertex count only while no square item is in progress.
`default_nettype none

`include "assert_macros.svh"

module two_step_path_counter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_data_i,
  tspc_in_if.sink          item_i,
  tspc_out_if.source       result_o
);

  tspc_pkg::row_t   rows_q [tspc_pkg::ROW_DEPTH];
  tspc_pkg::cnt_t   vertex_count_q;
  tspc_pkg::state_e state_q, state_d;
  tspc_pkg::vtx_t   row_q, row_d;
  tspc_pkg::vtx_t   col_q, col_d;

  logic             out_valid_q;
  tspc_pkg::vtx_t   out_row_q;
  tspc_pkg::vtx_t   out_col_q;
  tspc_pkg::cnt_t   out_cnt_q;
  logic             out_last_q;

  tspc_pkg::cnt_t   act_n;
  tspc_pkg::cnt_t   act_last;
  tspc_pkg::row_t   act_mask;
  tspc_pkg::row_t   col_vec;
  tspc_pkg::row_t   hit_vec;
  tspc_pkg::cnt_t   walk_cnt;
  logic             item_xfer;
  logic             emit;
  logic             row_end;
  logic             mat_end;
  tspc_pkg::op_e    op;

  assign act_n = (vertex_count_q > tspc_pkg::CNT_W'(tspc_pkg::MAX_VERTICES)) ?
                 tspc_pkg::CNT_W'(tspc_pkg::MAX_VERTICES) : vertex_count_q;
  assign act_last = act_n - tspc_pkg::CNT_W'(1);

  assign op        = tspc_pkg::op_e'(item_i.op);
  assign item_xfer = item_i.valid && item_i.ready;
  assign item_i.ready = (state_q == tspc_pkg::ST_IDLE);

  // shared unit: AND row r with column c over active vertices, then count
  always_comb begin
    for (int p = 0; p < tspc_pkg::ROW_DEPTH; p++) begin
      act_mask[tspc_pkg::VTX_W'(p)] = (tspc_pkg::CNT_W'(p) < act_n);
      col_vec[tspc_pkg::VTX_W'(p)]  = rows_q[tspc_pkg::VTX_W'(p)][col_q];
    end
    hit_vec  = rows_q[row_q] & col_vec & act_mask;
    walk_cnt = '0;
    for (int p = 0; p < tspc_pkg::ROW_DEPTH; p++) begin
      walk_cnt = walk_cnt + tspc_pkg::CNT_W'(hit_vec[tspc_pkg::VTX_W'(p)]);
    end
  end

  assign emit    = (state_q == tspc_pkg::ST_RUN) && (!out_valid_q || result_o.ready);
  assign row_end = ({1'b0, col_q} == act_last);
  assign mat_end = row_end && ({1'b0, row_q} == act_last);

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    unique case (state_q)
      tspc_pkg::ST_IDLE: begin
        if (item_xfer && op == tspc_pkg::OP_SQUARE && act_n != '0) begin
          state_d = tspc_pkg::ST_RUN;
          row_d   = '0;
          col_d   = '0;
        end
      end
      tspc_pkg::ST_RUN: begin
        if (emit) begin
          if (mat_end) begin
            state_d = tspc_pkg::ST_IDLE;
          end else if (row_end) begin
            row_d = row_q + tspc_pkg::VTX_W'(1);
            col_d = '0;
          end else begin
            col_d = col_q + tspc_pkg::VTX_W'(1);
          end
        end
      end
      default: state_d = tspc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= tspc_pkg::ST_IDLE;
      row_q          <= '0;
      col_q          <= '0;
      vertex_count_q <= tspc_pkg::CNT_W'(8);
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      if (cfg_we_i) begin
        vertex_count_q <= cfg_data_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < tspc_pkg::ROW_DEPTH; s++) begin
        rows_q[tspc_pkg::VTX_W'(s)] <= '0;
      end
    end else if (item_xfer) begin
      case (op)
        tspc_pkg::OP_CLEAR: begin
          for (int s = 0; s < tspc_pkg::ROW_DEPTH; s++) begin
            rows_q[tspc_pkg::VTX_W'(s)] <= '0;
          end
        end
        tspc_pkg::OP_EDGE: begin
          if ({1'b0, item_i.source_vertex} < act_n &&
              {1'b0, item_i.target_vertex} < act_n) begin
            rows_q[item_i.source_vertex][item_i.target_vertex] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_row_q  <= row_q;
      out_col_q  <= col_q;
      out_cnt_q  <= walk_cnt;
      out_last_q <= mat_end;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.row_index    = out_row_q;
  assign result_o.column_index = out_col_q;
  assign result_o.walk_count   = out_cnt_q;
  assign result_o.last         = out_last_q;

  `ASSERT_IMPLIES(a_run_in_range, state_q == tspc_pkg::ST_RUN,
                  ({1'b0, row_q} < act_n && {1'b0, col_q} < act_n), "walk index out of range")
  `ASSERT_IMPLIES(a_last_diag, result_o.valid && result_o.last,
                  result_o.row_index == result_o.column_index, "last off the diagonal")
  `ASSERT_NEXT(a_square_starts,
               item_xfer && op == tspc_pkg::OP_SQUARE && act_n != '0,
               state_q == tspc_pkg::ST_RUN && row_q == '0 && col_q == '0,
               "square item did not start the walk")
  `ASSERT_ALWAYS(a_count_bound, !result_o.valid ||
                 result_o.walk_count <= tspc_pkg::CNT_W'(tspc_pkg::MAX_VERTICES),
                 "walk count above vertex limit")

endmodule

`default_nettype wire

### tb/two_step_path_counter_tb.sv
`timescale 1ns / 1ps
// Testbench of two_step_path_counter: directed and random clear, edge, square
// and spare-op transfers checked against an in-bench model of the matrix and its square.
// Depends on tspc_pkg, tspc_in_if, tspc_out_if and the RTL of the block.

module two_step_path_counter_tb;

  localparam logic [tspc_pkg::OP_W-1:0] OP_SPARE = 2'd3;
  localparam int unsigned IDLE_PCT = 17;
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef struct {
    logic [tspc_pkg::OP_W-1:0] op;
    tspc_pkg::vtx_t            src;
    tspc_pkg::vtx_t            dst;
  } graph_item_t;

  typedef struct {
    tspc_pkg::vtx_t row;
    tspc_pkg::vtx_t col;
    tspc_pkg::cnt_t count;
    logic           last;
  } walk_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [3:0] cfg_data_i = '0;
  logic       steady = 1'b0;
  int unsigned fail_count = 0;

  tspc_in_if  item_if ();
  tspc_out_if result_if ();

  two_step_path_counter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_if),
    .result_o   (result_if)
  );

  always #4 clk_i = ~clk_i;

  graph_item_t    item_queue[$];
  walk_t          due_walks[$];
  tspc_pkg::row_t adj_rows[tspc_pkg::ROW_DEPTH];
  logic [3:0]     vertex_count = 4'd8;

  function automatic int unsigned active_vertices();
    return (vertex_count > tspc_pkg::MAX_VERTICES) ? tspc_pkg::MAX_VERTICES :
           int'(vertex_count);
  endfunction

  function automatic void apply_graph_item(input logic [tspc_pkg::OP_W-1:0] op,
                                           input tspc_pkg::vtx_t src,
                                           input tspc_pkg::vtx_t dst);
    int unsigned n;
    walk_t       w;
    n = active_vertices();
    case (op)
      tspc_pkg::OP_CLEAR: begin
        foreach (adj_rows[i]) adj_rows[i] = '0;
      end
      tspc_pkg::OP_EDGE: begin
        if (src < n && dst < n) adj_rows[src][dst] = 1'b1;
      end
      tspc_pkg::OP_SQUARE: begin
        for (int unsigned r = 0; r < n; r++) begin
          for (int unsigned c = 0; c < n; c++) begin
            w.row   = tspc_pkg::vtx_t'(r);
            w.col   = tspc_pkg::vtx_t'(c);
            w.count = '0;
            for (int unsigned p = 0; p < n; p++) begin
              if (adj_rows[r][p] && adj_rows[p][c]) w.count = w.count + 1'b1;
            end
            w.last = (r == n - 1 && c == n - 1);
            due_walks.push_back(w);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_item(input logic [tspc_pkg::OP_W-1:0] op,
                                     input int unsigned src, input int unsigned dst);
    graph_item_t it;
    it.op  = op;
    it.src = tspc_pkg::vtx_t'(src);
    it.dst = tspc_pkg::vtx_t'(dst);
    item_queue.push_back(it);
  endfunction

  function automatic int unsigned pick_vertex();
    int unsigned n;
    n = active_vertices();
    if (n != 0 && $urandom_range(0, 9) < 8) return $urandom_range(0, n - 1);
    return $urandom_range(0, 7);
  endfunction

  function automatic void queue_random_items(input int unsigned count);
    int unsigned roll;
    for (int unsigned i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        queue_item(tspc_pkg::OP_CLEAR, $urandom_range(0, 7), $urandom_range(0, 7));
      end else if (roll < 80) begin
        queue_item(tspc_pkg::OP_EDGE, pick_vertex(), pick_vertex());
      end else if (roll < 96) begin
        queue_item(tspc_pkg::OP_SQUARE, $urandom_range(0, 7), $urandom_range(0, 7));
      end else begin
        queue_item(OP_SPARE, $urandom_range(0, 7), $urandom_range(0, 7));
      end
    end
  endfunction

  // Hold until every item is taken and every result has come back.
  task automatic wait_drained();
    while (item_queue.size() != 0 || item_if.valid || due_walks.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_vertex_count(input logic [3:0] value);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    vertex_count = value;
  endtask

  always @(posedge clk_i) begin : driver
    graph_item_t nxt;
    if (item_if.valid && item_if.ready)
      apply_graph_item(item_if.op, item_if.source_vertex, item_if.target_vertex);
    if (!item_if.valid || item_if.ready) begin
      if (item_queue.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = item_queue.pop_front();
        item_if.valid         <= 1'b1;
        item_if.op            <= nxt.op;
        item_if.source_vertex <= nxt.src;
        item_if.target_vertex <= nxt.dst;
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    walk_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (due_walks.size() == 0) begin
        $error("result transfer with none expected: row %0d column %0d",
               result_if.row_index, result_if.column_index);
        fail_count++;
      end else begin
        want = due_walks.pop_front();
        if (result_if.row_index !== want.row) begin
          $error("row_index: expected %0d, got %0d", want.row, result_if.row_index);
          fail_count++;
        end
        if (result_if.column_index !== want.col) begin
          $error("column_index: expected %0d, got %0d", want.col, result_if.column_index);
          fail_count++;
        end
        if (result_if.walk_count !== want.count) begin
          $error("walk_count: expected %0d, got %0d", want.count, result_if.walk_count);
          fail_count++;
        end
        if (result_if.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, result_if.last);
          fail_count++;
        end
      end
    end
    result_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [3:0]  counts[8];
    int unsigned lengths[8];
    counts  = '{4'd8, 4'd2, 4'd15, 4'd5, 4'd1, 4'd8, 4'd0, 4'd6};
    lengths = '{50, 45, 50, 45, 40, 50, 20, 50};
    item_if.valid         = 1'b0;
    item_if.op            = tspc_pkg::OP_CLEAR;
    item_if.source_vertex = '0;
    item_if.target_vertex = '0;
    result_if.ready       = 1'b0;
    foreach (adj_rows[i]) adj_rows[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full row 0 and full column 0 give the largest count on entry (0, 0).
    queue_item(tspc_pkg::OP_CLEAR, 7, 7);
    for (int unsigned k = 0; k < 8; k++) queue_item(tspc_pkg::OP_EDGE, 0, k);
    for (int unsigned k = 1; k < 8; k++) queue_item(tspc_pkg::OP_EDGE, k, 0);
    queue_item(tspc_pkg::OP_SQUARE, 0, 0);
    queue_item(OP_SPARE, 7, 7);
    queue_item(tspc_pkg::OP_SQUARE, 7, 7);
    queue_item(tspc_pkg::OP_CLEAR, 0, 0);
    queue_item(tspc_pkg::OP_EDGE, 6, 5);
    queue_item(tspc_pkg::OP_SQUARE, 0, 0);

    set_vertex_count(4'd3);
    queue_item(tspc_pkg::OP_EDGE, 3, 1);
    queue_item(tspc_pkg::OP_EDGE, 1, 3);
    queue_item(tspc_pkg::OP_EDGE, 2, 2);
    queue_item(tspc_pkg::OP_SQUARE, 0, 0);

    set_vertex_count(4'd0);
    queue_item(tspc_pkg::OP_EDGE, 0, 0);
    queue_item(tspc_pkg::OP_SQUARE, 0, 0);

    set_vertex_count(4'd15);
    queue_item(tspc_pkg::OP_EDGE, 7, 7);
    queue_item(tspc_pkg::OP_SQUARE, 0, 0);

    set_vertex_count(4'd1);
    queue_item(tspc_pkg::OP_EDGE, 0, 0);
    queue_item(tspc_pkg::OP_SQUARE, 0, 0);

    foreach (counts[i]) begin
      set_vertex_count(counts[i]);
      steady <= (i == 5);
      queue_random_items(lengths[i]);
    end

    wait_drained();
    if (fail_count == 0 && due_walks.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
